// File: rtl/hsg_pkg.sv
// Shared types, constants and helper functions of the sound generator.
package hsg_pkg;

  localparam int unsigned HSG_CPU_CLOCK = 4194304;
  localparam logic [12:0] HSG_TICKS_RESET = 13'd95;

  // Sound register offsets
  localparam logic [7:0] OFF_SWEEP    = 8'h10;
  localparam logic [7:0] OFF_SQ1_DUTY = 8'h11;
  localparam logic [7:0] OFF_SQ1_ENV  = 8'h12;
  localparam logic [7:0] OFF_SQ1_FLO  = 8'h13;
  localparam logic [7:0] OFF_SQ1_FHI  = 8'h14;
  localparam logic [7:0] OFF_SQ2_DUTY = 8'h16;
  localparam logic [7:0] OFF_SQ2_ENV  = 8'h17;
  localparam logic [7:0] OFF_SQ2_FLO  = 8'h18;
  localparam logic [7:0] OFF_SQ2_FHI  = 8'h19;
  localparam logic [7:0] OFF_NZ_LEN   = 8'h20;
  localparam logic [7:0] OFF_NZ_ENV   = 8'h21;
  localparam logic [7:0] OFF_NZ_POLY  = 8'h22;
  localparam logic [7:0] OFF_NZ_CTRL  = 8'h23;
  localparam logic [7:0] OFF_LEVELS   = 8'h24;
  localparam logic [7:0] OFF_PAN      = 8'h25;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SEL, ST_SQ_DSUB, ST_SQ_DRLD, ST_SQ_PSUB, ST_SQ_PRLD, ST_SQ_PDUTY,
    ST_LEN, ST_LEN_RLD, ST_ENV, ST_ENV_RLD, ST_SW_SUB, ST_SW_RLD, ST_SW_DUTY,
    ST_P1_GO, ST_P1_WAIT, ST_P2_GO, ST_P2_WAIT, ST_P_DONE, ST_N_GO, ST_N_WAIT,
    ST_NZ_SUB, ST_NZ_RLD, ST_MIX, ST_SCALE
  } st_e;

  // Saturate a grown sum to the 24-bit signed range
  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > 26'sd8388607) r = 24'sh7fffff;
    else if (v < -26'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  // Duty split of a period count, truncated toward zero
  function automatic logic signed [23:0] duty_part(input logic signed [23:0] cnt,
                                                   input logic [1:0] d);
    logic        neg;
    logic [25:0] mag;
    logic [25:0] res;
    neg = cnt[23];
    mag = neg ? 26'(-{{2{cnt[23]}}, cnt}) : {2'b00, cnt};
    if (d == 2'd3) res = (mag + (mag << 1)) >> 2;
    else res = mag >> (2'd3 - d);
    if (neg) res = -res;
    return res[23:0];
  endfunction

  // 1048576 divided by 1..8
  function automatic logic [20:0] noise_base(input logic [2:0] r);
    logic [20:0] b;
    case (r)
      3'd0: b = 21'd1048576;
      3'd1: b = 21'd524288;
      3'd2: b = 21'd349525;
      3'd3: b = 21'd262144;
      3'd4: b = 21'd209715;
      3'd5: b = 21'd174762;
      3'd6: b = 21'd149796;
      default: b = 21'd131072;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/hsg_div.sv
// Restoring divider, one quotient bit per cycle, 24-bit operands.
module hsg_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] dividend_i,
  input  logic [23:0] divisor_i,
  output logic        busy_o,
  output logic [23:0] quot_o
);

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [23:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [24:0] trial, diff;

  // Shift in one dividend bit and try the subtraction
  always_comb begin
    trial  = {rem_q, quo_q[23]};
    diff   = trial - {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd24;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[23:0];
        quo_d = {quo_q[22:0], 1'b1};
      end else begin
        rem_d = trial[23:0];
        quo_d = {quo_q[22:0], 1'b0};
      end
      cnt_d  = cnt_q - 5'd1;
      busy_d = cnt_q != 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold the datapath words
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

// File: rtl/handheld_sound_generator_core.sv
// Top level of the sound generator: register file, channel sequencer and mixer.
//
//  channel | handshake                  | word
//  --------+----------------------------+------------------------------------------
//  input   | in_valid_i / in_stall_o    | cmd_i, reg_offset_i, reg_value_i
//  output  | out_valid_o / out_stall_i  | left_sample_o, right_sample_o,
//          |                            | channel_status_o
//  config  | cfg_we_i                   | cfg_data_i (ticks per sample)
//
// A plain register write is done in the idle state; a frequency write makes two
// passes of the 24-bit divider, a noise polynomial write one (skipped at rate zero).
// A sample step runs through one shared saturating adder; a sweep step that retunes
// square one adds the two divider passes, and an output stall holds the step.
// Reset is asynchronous and active low and brings every timer to its start value.
// The input stalls while a word is being worked; a finished sample waits for a
// stalled output register before the block goes idle again.
module handheld_sound_generator_core
  import hsg_pkg::*;
#(
  parameter int unsigned CpuClock = HSG_CPU_CLOCK
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [0:0]         cmd_i,
  input  logic [7:0]         reg_offset_i,
  input  logic [7:0]         reg_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] left_sample_o,
  output logic signed [15:0] right_sample_o,
  output logic [3:0]         channel_status_o,
  input  logic               cfg_we_i,
  input  logic [12:0]        cfg_data_i
);

  localparam logic [23:0] CpuW   = 24'(CpuClock);
  localparam logic [23:0] LenRld = 24'(CpuClock / 256);
  localparam logic [23:0] EnvRld = 24'(CpuClock / 64);
  localparam logic [23:0] SwRld  = 24'(CpuClock / 128);

  st_e state_q, state_d;
  logic [1:0] ch_q, ch_d;
  logic       ctx_q, ctx_d;
  logic [12:0] ticks_q, ticks_d;

  // Square channels
  logic [7:0]         flo_q [2], flo_d [2];
  logic [2:0]         fhi_q [2], fhi_d [2];
  logic [10:0]        freq_q [2], freq_d [2];
  logic signed [23:0] per_q [2], per_d [2];
  logic signed [23:0] duty_q [2], duty_d [2];
  logic signed [23:0] pref_q [2], pref_d [2];
  logic               phase_q [2], phase_d [2];
  logic [1:0]         dsel_q [2], dsel_d [2];
  logic [5:0]         lreg_q [2], lreg_d [2];

  // Per channel length and envelope, noise last
  logic [6:0]         lleft_q [3], lleft_d [3];
  logic               len_q [3], len_d [3];
  logic signed [23:0] ltmr_q [3], ltmr_d [3];
  logic [2:0]         esteps_q [3], esteps_d [3];
  logic signed [23:0] etmr_q [3], etmr_d [3];
  logic               eup_q [3], eup_d [3];
  logic [3:0]         vol_q [3], vol_d [3];
  logic               run_q [3], run_d [3];
  logic [2:0]         ereg_q [3], ereg_d [3];

  // Sweep
  logic [2:0]         swsteps_q, swsteps_d, swreg_q, swreg_d, swshift_q, swshift_d;
  logic               swdown_q, swdown_d;
  logic signed [23:0] swtmr_q, swtmr_d;

  // Noise
  logic [14:0]        lfsr_q, lfsr_d, nout_q, nout_d;
  logic [19:0]        nrate_q, nrate_d;
  logic signed [23:0] nper_q, nper_d, nrld_q, nrld_d;
  logic               narrow_q, narrow_d;

  logic [5:0] pan_q, pan_d, lvl_q, lvl_d;
  logic [3:0] stat_q, stat_d, pre_q, pre_d;
  logic signed [7:0] accl_q, accl_d, accr_q, accr_d;

  // Output register
  logic               ovalid_q, ovalid_d;
  logic signed [15:0] oleft_q, oleft_d, oright_q, oright_d;
  logic [3:0]         ostat_q, ostat_d;

  // Shared adder and divider
  logic signed [23:0] au_a, au_b, au_sum;
  logic               au_le0;
  logic               div_start, div_busy;
  logic [23:0]        div_divisor, div_quot;
  logic signed [23:0] qs;

  logic c;
  assign c = ch_q[0];

  hsg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (CpuW),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  assign qs = div_quot[23] ? 24'sh7fffff : $signed(div_quot);

  // Scale a side sum by its level times 64 and clamp
  function automatic logic signed [15:0] scale16(input logic signed [7:0] v,
                                                 input logic [2:0] l);
    logic signed [11:0] p;
    logic signed [17:0] w;
    logic signed [15:0] r;
    p = v * $signed({1'b0, l});
    w = {p, 6'b0};
    if (w > 18'sd32767) r = 16'sd32767;
    else if (w < -18'sd32767) r = -16'sd32767;
    else r = w[15:0];
    return r;
  endfunction

  // Pick adder operands for the current step
  always_comb begin
    logic signed [23:0] neg_t;
    neg_t = -$signed({11'b0, ticks_q});
    au_a  = '0;
    au_b  = '0;
    case (state_q)
      ST_SQ_DSUB:  begin au_a = duty_q[c]; au_b = neg_t; end
      ST_SQ_DRLD:  begin
        au_a = per_q[c];
        au_b = $signed({11'b0, ticks_q}) + (c ? 24'sd1 : 24'sd5);
      end
      ST_SQ_PSUB:  begin au_a = per_q[c]; au_b = neg_t; end
      ST_SQ_PRLD:  begin au_a = per_q[c]; au_b = pref_q[c]; end
      ST_SQ_PDUTY, ST_SW_DUTY: begin
        au_a = duty_q[c]; au_b = duty_part(per_q[c], dsel_q[c]);
      end
      ST_LEN:      begin au_a = ltmr_q[ch_q]; au_b = neg_t; end
      ST_LEN_RLD:  begin au_a = ltmr_q[ch_q]; au_b = $signed(LenRld); end
      ST_ENV:      begin au_a = etmr_q[ch_q]; au_b = neg_t; end
      ST_ENV_RLD:  begin au_a = etmr_q[ch_q]; au_b = $signed(EnvRld); end
      ST_SW_SUB:   begin au_a = swtmr_q; au_b = neg_t; end
      ST_SW_RLD:   begin au_a = swtmr_q; au_b = $signed(SwRld); end
      ST_P_DONE:   begin au_a = per_q[c]; au_b = qs; end
      ST_NZ_SUB:   begin au_a = nper_q; au_b = neg_t; end
      ST_NZ_RLD:   begin au_a = nper_q; au_b = nrld_q; end
      default:     begin au_a = '0; au_b = '0; end
    endcase
    au_sum = sat24(26'(au_a) + 26'(au_b));
    au_le0 = au_sum[23] || (au_sum == '0);
  end

  // Divider operands
  always_comb begin
    div_start   = (state_q == ST_P1_GO) || (state_q == ST_P2_GO) || (state_q == ST_N_GO);
    div_divisor = 24'(nrate_q);
    if (state_q == ST_P1_GO) begin
      div_divisor = 24'({12'd2048 - {1'b0, freq_q[c]}, 5'b0});
    end else if (state_q == ST_P2_GO) begin
      div_divisor = (div_quot == '0) ? 24'd1 : div_quot;
    end
  end

  // Sequencer: next state and register updates
  always_comb begin
    logic       wc;
    logic [7:0] v;
    logic [4:0] sh;
    logic [2:0] stn;
    logic [10:0] f, dlt;
    logic [11:0] fs;
    logic [14:0] ls;
    logic        fb;
    logic signed [4:0] s;
    logic [3:0]  sbit;
    st_e         post_env;

    state_d = state_q; ch_d = ch_q; ctx_d = ctx_q;
    ticks_d = cfg_we_i ? cfg_data_i : ticks_q;
    flo_d = flo_q; fhi_d = fhi_q; freq_d = freq_q; per_d = per_q; duty_d = duty_q;
    pref_d = pref_q; phase_d = phase_q; dsel_d = dsel_q; lreg_d = lreg_q;
    lleft_d = lleft_q; len_d = len_q; ltmr_d = ltmr_q; esteps_d = esteps_q;
    etmr_d = etmr_q; eup_d = eup_q; vol_d = vol_q; run_d = run_q; ereg_d = ereg_q;
    swsteps_d = swsteps_q; swreg_d = swreg_q; swshift_d = swshift_q;
    swdown_d = swdown_q; swtmr_d = swtmr_q;
    lfsr_d = lfsr_q; nout_d = nout_q; nrate_d = nrate_q; nper_d = nper_q;
    nrld_d = nrld_q; narrow_d = narrow_q;
    pan_d = pan_q; lvl_d = lvl_q; stat_d = stat_q; pre_d = pre_q;
    accl_d = accl_q; accr_d = accr_q;
    ovalid_d = ovalid_q && out_stall_i;
    oleft_d = oleft_q; oright_d = oright_q; ostat_d = ostat_q;

    v   = reg_value_i;
    wc  = reg_offset_i > OFF_SQ1_FHI;
    sh  = {1'b0, v[7:4]} + 5'd1;
    stn = '0;
    f   = freq_q[0];
    dlt = freq_q[0] >> swshift_q;
    fs  = '0;
    fb  = lfsr_q[1] ^ lfsr_q[0];
    ls  = {1'b0, lfsr_q[14:1]};
    s   = '0;
    case (ch_q)
      2'd0:    sbit = 4'b0001;
      2'd1:    sbit = 4'b0010;
      default: sbit = 4'b1000;
    endcase
    post_env = ((ch_q == 2'd0) && (swsteps_q != 3'd0)) ? ST_SW_SUB : ST_MIX;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i[0]) begin
            accl_d = '0; accr_d = '0; ch_d = 2'd0;
            state_d = ST_SEL;
          end else begin
            case (reg_offset_i)
              OFF_SWEEP: begin
                swsteps_d = v[6:4]; swreg_d = v[6:4]; swdown_d = v[3]; swshift_d = v[2:0];
              end
              OFF_SQ1_DUTY, OFF_SQ2_DUTY: begin
                dsel_d[wc]  = v[7:6];
                lreg_d[wc]  = v[5:0];
                lleft_d[wc] = 7'd64 - {1'b0, v[5:0]};
                duty_d[wc]  = duty_part(per_q[wc], v[7:6]);
              end
              OFF_SQ1_ENV, OFF_SQ2_ENV: begin
                vol_d[wc] = v[7:4]; eup_d[wc] = v[3];
                esteps_d[wc] = v[2:0]; ereg_d[wc] = v[2:0];
              end
              OFF_SQ1_FLO, OFF_SQ2_FLO: begin
                flo_d[wc]  = v;
                freq_d[wc] = {fhi_q[wc], v};
                ch_d = {1'b0, wc}; ctx_d = 1'b0;
                state_d = ST_P1_GO;
              end
              OFF_SQ1_FHI, OFF_SQ2_FHI: begin
                fhi_d[wc]  = v[2:0];
                freq_d[wc] = {v[2:0], flo_q[wc]};
                len_d[wc]  = v[6];
                if (v[7]) begin
                  run_d[wc]    = 1'b1;
                  lleft_d[wc]  = 7'd64 - {1'b0, lreg_q[wc]};
                  esteps_d[wc] = ereg_q[wc];
                  if (!wc) swsteps_d = swreg_q;
                  phase_d[wc]  = 1'b1;
                  stat_d = stat_q | (wc ? 4'b0010 : 4'b0001);
                end
                ch_d = {1'b0, wc}; ctx_d = 1'b0;
                state_d = ST_P1_GO;
              end
              OFF_NZ_LEN: lleft_d[2] = 7'd64 - {1'b0, v[5:0]};
              OFF_NZ_ENV: begin
                vol_d[2] = v[7:4]; eup_d[2] = v[3];
                esteps_d[2] = v[2:0]; ereg_d[2] = v[2:0];
              end
              OFF_NZ_POLY: begin
                narrow_d = v[3];
                nrate_d  = 20'(noise_base(v[2:0]) >> sh);
                state_d  = ST_N_GO;
              end
              OFF_NZ_CTRL: begin
                len_d[2] = v[6];
                if (v[7]) begin
                  run_d[2] = 1'b1; stat_d = stat_q | 4'b1000;
                  nout_d = 15'h7fff; lfsr_d = 15'h7fff;
                  esteps_d[2] = ereg_q[2];
                end
              end
              OFF_LEVELS: lvl_d = {v[6:4], v[2:0]};
              OFF_PAN:    pan_d = {v[7], v[5], v[4], v[3], v[1], v[0]};
              default: ;
            endcase
          end
        end
      end

      // Frequency to period: two divides
      ST_P1_GO:   state_d = ST_P1_WAIT;
      ST_P1_WAIT: if (!div_busy) state_d = ST_P2_GO;
      ST_P2_GO:   state_d = ST_P2_WAIT;
      ST_P2_WAIT: if (!div_busy) state_d = ST_P_DONE;
      ST_P_DONE: begin
        pref_d[c] = qs;
        if (ctx_q) begin
          per_d[c] = au_sum;
          state_d  = ST_SW_DUTY;
        end else begin
          per_d[c]  = qs;
          duty_d[c] = duty_part(qs, dsel_q[c]);
          state_d   = ST_IDLE;
        end
      end
      ST_SW_DUTY: begin
        duty_d[c] = au_sum;
        state_d   = ST_MIX;
      end

      // Noise period from its rate
      ST_N_GO: begin
        if (nrate_q == '0) begin
          nper_d = '0; state_d = ST_IDLE;
        end else begin
          state_d = ST_N_WAIT;
        end
      end
      ST_N_WAIT: begin
        if (!div_busy) begin
          nper_d = qs; nrld_d = qs; state_d = ST_IDLE;
        end
      end

      // Skip channels that are stopped
      ST_SEL: begin
        if (ch_q == 2'd3) begin
          state_d = ST_SCALE;
        end else if (run_q[ch_q]) begin
          pre_d   = vol_q[ch_q];
          state_d = (ch_q == 2'd2) ? ST_NZ_SUB : ST_SQ_DSUB;
        end else begin
          ch_d = ch_q + 2'd1;
        end
      end

      ST_SQ_DSUB: begin
        duty_d[c] = au_sum;
        state_d   = au_le0 ? ST_SQ_DRLD : ST_SQ_PSUB;
      end
      ST_SQ_DRLD: begin
        duty_d[c]  = au_sum;
        phase_d[c] = !phase_q[c];
        state_d    = ST_SQ_PSUB;
      end
      ST_SQ_PSUB: begin
        per_d[c] = au_sum;
        if (au_le0) begin
          phase_d[c] = !phase_q[c];
          state_d    = ST_SQ_PRLD;
        end else begin
          state_d = ST_LEN;
        end
      end
      ST_SQ_PRLD: begin
        per_d[c] = au_sum;
        state_d  = ST_SQ_PDUTY;
      end
      ST_SQ_PDUTY: begin
        duty_d[c] = au_sum;
        state_d   = ST_LEN;
      end

      // Length counter
      ST_LEN: begin
        state_d = ST_ENV;
        if (len_q[ch_q] && (lleft_q[ch_q] != '0)) begin
          ltmr_d[ch_q] = au_sum;
          if (au_le0) state_d = ST_LEN_RLD;
        end
      end
      ST_LEN_RLD: begin
        ltmr_d[ch_q]  = au_sum;
        lleft_d[ch_q] = lleft_q[ch_q] - 7'd1;
        if (lleft_q[ch_q] == 7'd1) begin
          run_d[ch_q] = 1'b0;
          stat_d      = stat_q & ~sbit;
        end
        state_d = ST_ENV;
      end

      // Envelope
      ST_ENV: begin
        state_d = post_env;
        if (esteps_q[ch_q] != '0) begin
          etmr_d[ch_q] = au_sum;
          if (au_le0) state_d = ST_ENV_RLD;
        end
      end
      ST_ENV_RLD: begin
        etmr_d[ch_q] = au_sum;
        stn = esteps_q[ch_q] - 3'd1;
        esteps_d[ch_q] = stn;
        if (stn == '0) begin
          esteps_d[ch_q] = ereg_q[ch_q];
          if (eup_q[ch_q]) begin
            if (vol_q[ch_q] != 4'd15) vol_d[ch_q] = vol_q[ch_q] + 4'd1;
          end else if (vol_q[ch_q] <= 4'd1) begin
            vol_d[ch_q] = '0;
            if (ch_q == 2'd2) run_d[2] = 1'b0;
          end else begin
            vol_d[ch_q] = vol_q[ch_q] - 4'd1;
          end
        end
        state_d = post_env;
      end

      // Frequency sweep of square one
      ST_SW_SUB: begin
        swtmr_d = au_sum;
        state_d = au_le0 ? ST_SW_RLD : ST_MIX;
      end
      ST_SW_RLD: begin
        swtmr_d   = au_sum;
        stn       = swsteps_q - 3'd1;
        swsteps_d = stn;
        state_d   = ST_MIX;
        if (stn == '0) begin
          swsteps_d = swreg_q;
          if (!swdown_q) begin
            fs = {1'b0, f} + {1'b0, dlt};
            f  = fs[11] ? 11'd2047 : fs[10:0];
          end else begin
            f = f - dlt;
            if (f == '0) begin
              run_d[0] = 1'b0;
              stat_d   = stat_d & 4'b1110;
            end
          end
          freq_d[0] = f;
          ctx_d     = 1'b1;
          state_d   = ST_P1_GO;
        end
      end

      // Noise shift register
      ST_NZ_SUB: begin
        state_d = ST_LEN;
        if (nrate_q != '0) begin
          nper_d = au_sum;
          if (au_le0) state_d = ST_NZ_RLD;
        end
      end
      ST_NZ_RLD: begin
        nper_d = au_sum;
        if (narrow_q) ls = (ls | {8'b0, fb, 6'b0}) & 15'h007f;
        else ls = ls | {fb, 14'b0};
        lfsr_d  = ls;
        nout_d  = ls;
        state_d = ST_LEN;
      end

      // Add this channel into each side that its pan bit enables
      ST_MIX: begin
        if (ch_q == 2'd2) begin
          if (pan_q[5]) accl_d = accl_q + $signed({3'b0, nout_q[3:0] & vol_q[2], 1'b0});
          if (pan_q[2]) accr_d = accr_q + $signed({3'b0, nout_q[3:0] & vol_q[2], 1'b0});
        end else begin
          s = $signed({1'b0, c ? vol_q[1] : pre_q});
          if (!phase_q[c]) s = -s;
          if (pan_q[c ? 3'd4 : 3'd3]) accl_d = accl_q + 8'(s);
          if (pan_q[{2'b00, c}]) accr_d = accr_q + 8'(s);
        end
        ch_d    = ch_q + 2'd1;
        state_d = ST_SEL;
      end

      // Scale and hand the word to the output register
      ST_SCALE: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          oleft_d  = scale16(accl_q, lvl_q[5:3]);
          oright_d = scale16(accr_q, lvl_q[2:0]);
          ostat_d  = stat_q;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ch_q <= '0; ctx_q <= 1'b0; ticks_q <= HSG_TICKS_RESET;
      flo_q <= '{default: '0}; fhi_q <= '{default: '0}; freq_q <= '{default: '0};
      per_q <= '{default: '0}; duty_q <= '{default: '0}; pref_q <= '{default: '0};
      phase_q <= '{default: 1'b1}; dsel_q <= '{default: '0}; lreg_q <= '{default: '0};
      lleft_q <= '{default: '0}; len_q <= '{default: 1'b0};
      ltmr_q <= '{default: $signed(LenRld)}; esteps_q <= '{default: '0};
      etmr_q <= '{default: $signed(EnvRld)}; eup_q <= '{default: 1'b0};
      vol_q <= '{default: '0}; run_q <= '{default: 1'b0}; ereg_q <= '{default: '0};
      swsteps_q <= '0; swreg_q <= '0; swshift_q <= '0; swdown_q <= 1'b0;
      swtmr_q <= $signed(SwRld);
      lfsr_q <= 15'h00ff; nout_q <= '0; nrate_q <= '0; nper_q <= '0; nrld_q <= '0;
      narrow_q <= 1'b0;
      pan_q <= 6'h1b; lvl_q <= '0; stat_q <= '0; pre_q <= '0;
      accl_q <= '0; accr_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; ch_q <= ch_d; ctx_q <= ctx_d; ticks_q <= ticks_d;
      flo_q <= flo_d; fhi_q <= fhi_d; freq_q <= freq_d;
      per_q <= per_d; duty_q <= duty_d; pref_q <= pref_d;
      phase_q <= phase_d; dsel_q <= dsel_d; lreg_q <= lreg_d;
      lleft_q <= lleft_d; len_q <= len_d; ltmr_q <= ltmr_d; esteps_q <= esteps_d;
      etmr_q <= etmr_d; eup_q <= eup_d; vol_q <= vol_d; run_q <= run_d;
      ereg_q <= ereg_d;
      swsteps_q <= swsteps_d; swreg_q <= swreg_d; swshift_q <= swshift_d;
      swdown_q <= swdown_d; swtmr_q <= swtmr_d;
      lfsr_q <= lfsr_d; nout_q <= nout_d; nrate_q <= nrate_d; nper_q <= nper_d;
      nrld_q <= nrld_d; narrow_q <= narrow_d;
      pan_q <= pan_d; lvl_q <= lvl_d; stat_q <= stat_d; pre_q <= pre_d;
      accl_q <= accl_d; accr_q <= accr_d; ovalid_q <= ovalid_d;
    end
  end

  // Hold the output word
  always_ff @(posedge clk_i) begin
    oleft_q  <= oleft_d;
    oright_q <= oright_d;
    ostat_q  <= ostat_d;
  end

  assign in_stall_o       = state_q != ST_IDLE;
  assign out_valid_o      = ovalid_q;
  assign left_sample_o    = oleft_q;
  assign right_sample_o   = oright_q;
  assign channel_status_o = ostat_q;

endmodule
